[hdl/hcg_pkg.sv]
// Shared types, constants and helper functions for the hex cell geometry block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package hcg_pkg;

  // Field widths of the words that enter and leave the block.
  localparam int CoordW = 8;
  localparam int DimW   = 9;
  localparam int GeoW   = 16;
  localparam int PosW   = 25;
  localparam int SlotW  = 3;
  localparam int CfgIdxW = 2;

  // Six direction slots per cell, clockwise from the top.
  localparam int SLOTS = 6;
  localparam logic [SlotW-1:0] SLOT_FIRST = 3'd0;
  localparam logic [SlotW-1:0] SLOT_LAST  = 3'd5;

  // Largest grid dimension; the 8-bit neighbor fields cap it at 256.
  localparam int MAX_DIM = 256;
  localparam int DIM_CAP = (MAX_DIM < 256) ? MAX_DIM : 256;
  localparam logic [DimW-1:0] DIM_LIMIT = DIM_CAP[DimW-1:0];

  // Depth of the queue between the front and back halves.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_ROWS    = 2'd0,
    REG_NUM_COLS    = 2'd1,
    REG_CELL_WIDTH  = 2'd2,
    REG_CELL_HEIGHT = 2'd3
  } hcg_reg_t;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [DimW-1:0] num_rows;
    logic [DimW-1:0] num_cols;
    logic [GeoW-1:0] cell_width;
    logic [GeoW-1:0] cell_height;
  } hcg_cfg_t;

  // One classified cell, handed from the front half to the back half.
  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              outside;
    logic [PosW-1:0]   centre_x;
    logic [PosW-1:0]   centre_y;
  } hcg_entry_t;

  // Clamp a configured dimension to what the grid can address.
  function automatic logic [DimW-1:0] limit_dim(input logic [DimW-1:0] v);
    limit_dim = (v > DIM_LIMIT) ? DIM_LIMIT : v;
  endfunction

  // Row step of the neighbor in a slot; the same for odd and even rows.
  function automatic logic signed [1:0] nbr_drow(input logic [SlotW-1:0] s);
    case (s)
      3'd0:    nbr_drow = -2'sd1;
      3'd1:    nbr_drow = 2'sd0;
      3'd2:    nbr_drow = 2'sd1;
      3'd3:    nbr_drow = 2'sd1;
      3'd4:    nbr_drow = 2'sd0;
      3'd5:    nbr_drow = -2'sd1;
      default: nbr_drow = 2'sd0;
    endcase
  endfunction

  // Column step of the neighbor in a slot; odd rows sit half a cell right.
  function automatic logic signed [1:0] nbr_dcol(input logic [SlotW-1:0] s,
                                                 input logic odd);
    if (odd) begin
      case (s)
        3'd0, 3'd1, 3'd2: nbr_dcol = 2'sd1;
        3'd4:             nbr_dcol = -2'sd1;
        default:          nbr_dcol = 2'sd0;
      endcase
    end else begin
      case (s)
        3'd1:             nbr_dcol = 2'sd1;
        3'd3, 3'd4, 3'd5: nbr_dcol = -2'sd1;
        default:          nbr_dcol = 2'sd0;
      endcase
    end
  endfunction

endpackage

`default_nettype wire

[hdl/hex_cell_geometry_and_neighbors.sv]
// Top level of the hex cell geometry block: config registers, front half, queue, back half.
// Depends on hcg_pkg, hcg_front, hcg_queue and hcg_back.
// A taken cell passes through the product stage, the queue store and the result register.
// Six result words per cell, one per cycle while the output is popped, set by the slot walk;
// a cell can be taken every cycle until the queue fills, then only as the back half pops it.
// Reset (rst, synchronous) empties the pipeline and queue and loads the default geometry.
`default_nettype none

module hex_cell_geometry_and_neighbors #(
  parameter int QUEUE_DEPTH = hcg_pkg::QUEUE_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [hcg_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [hcg_pkg::GeoW-1:0]    cfg_data,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [hcg_pkg::CoordW-1:0]  cell_row,
  input  wire logic [hcg_pkg::CoordW-1:0]  cell_col,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [hcg_pkg::SlotW-1:0]        slot,
  output logic                             neighbor_valid,
  output logic [hcg_pkg::CoordW-1:0]       neighbor_row,
  output logic [hcg_pkg::CoordW-1:0]       neighbor_col,
  output logic [hcg_pkg::PosW-1:0]         centre_x,
  output logic [hcg_pkg::PosW-1:0]         centre_y,
  output logic [hcg_pkg::PosW-1:0]         corner_x,
  output logic [hcg_pkg::PosW-1:0]         corner_y,
  output logic                             outside,
  output logic                             last
);
  import hcg_pkg::*;

  hcg_cfg_t   cfg;
  hcg_entry_t q_wr_data;
  hcg_entry_t q_rd_data;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_rows    <= 9'd256;
      cfg.num_cols    <= 9'd256;
      cfg.cell_width  <= 16'd443;
      cfg.cell_height <= 16'd512;
    end else if (cfg_write) begin
      case (hcg_reg_t'(cfg_index))
        REG_NUM_ROWS:    cfg.num_rows    <= cfg_data[DimW-1:0];
        REG_NUM_COLS:    cfg.num_cols    <= cfg_data[DimW-1:0];
        REG_CELL_WIDTH:  cfg.cell_width  <= cfg_data;
        REG_CELL_HEIGHT: cfg.cell_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Query intake and cell classification.
  hcg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .cell_row (cell_row),
    .cell_col (cell_col),
    .q_push   (q_push),
    .q_data   (q_wr_data),
    .q_full   (q_full)
  );

  // Queue between the two halves.
  hcg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  // Slot walk and result register.
  hcg_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .q_data         (q_rd_data),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .slot           (slot),
    .neighbor_valid (neighbor_valid),
    .neighbor_row   (neighbor_row),
    .neighbor_col   (neighbor_col),
    .centre_x       (centre_x),
    .centre_y       (centre_y),
    .corner_x       (corner_x),
    .corner_y       (corner_y),
    .outside        (outside),
    .last           (last)
  );

endmodule

`default_nettype wire

[hdl/hcg_front.sv]
// Front half: accepts a cell query, works out its centre and whether it is outside the grid.
// Depends on hcg_pkg.
`default_nettype none

module hcg_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire hcg_pkg::hcg_cfg_t        cfg,
  input  wire logic                     push,
  output logic                          full,
  input  wire logic [hcg_pkg::CoordW-1:0] cell_row,
  input  wire logic [hcg_pkg::CoordW-1:0] cell_col,
  output logic                          q_push,
  output hcg_pkg::hcg_entry_t           q_data,
  input  wire logic                     q_full
);
  import hcg_pkg::*;

  logic                stage_valid;
  logic [CoordW-1:0]   stage_row;
  logic [CoordW-1:0]   stage_col;
  logic [23:0]         prod_x;
  logic [25:0]         prod_y;
  logic                advance;
  logic [9:0]          row3;
  logic [DimW-1:0]     rows;
  logic [DimW-1:0]     cols;
  logic [GeoW-2:0]     half_w;
  logic [GeoW-2:0]     half_h;

  // The product stage moves on whenever the queue can take its word.
  assign advance = !stage_valid || !q_full;
  assign full    = !advance;
  assign row3    = {1'b0, cell_row, 1'b0} + {2'b00, cell_row};

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (advance) begin
      stage_valid <= push;
    end
  end

  // Products of the query with the cell size, one multiplier per axis.
  always_ff @(posedge clk) begin
    if (advance && push) begin
      stage_row <= cell_row;
      stage_col <= cell_col;
      prod_x    <= cfg.cell_width * cell_col;
      prod_y    <= row3 * cfg.cell_height;
    end
  end

  // Centre sums and the outside check feed the queue.
  always_comb begin
    rows   = limit_dim(cfg.num_rows);
    cols   = limit_dim(cfg.num_cols);
    half_w = cfg.cell_width[GeoW-1:1];
    half_h = cfg.cell_height[GeoW-1:1];
    q_push = stage_valid;
    q_data.row      = stage_row;
    q_data.col      = stage_col;
    q_data.outside  = ({1'b0, stage_row} >= rows) || ({1'b0, stage_col} >= cols);
    q_data.centre_x = PosW'(half_w) + (stage_row[0] ? PosW'(half_w) : '0)
                      + PosW'(prod_x);
    q_data.centre_y = PosW'(half_h) + PosW'(prod_y[25:2]);
  end

endmodule

`default_nettype wire

[hdl/hcg_queue.sv]
// Short register queue that decouples the front half from the back half.
// Depends on hcg_pkg for the word type.
`default_nettype none

module hcg_queue #(
  parameter int DEPTH = hcg_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire hcg_pkg::hcg_entry_t wr_data,
  output logic                     q_full,
  input  wire logic                rd_en,
  output hcg_pkg::hcg_entry_t      rd_data,
  output logic                     q_empty
);
  import hcg_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PTR_LAST = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CNT_FULL = CntW'(DEPTH);

  hcg_entry_t       store [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_wr;
  logic             do_rd;

  assign q_full  = (count == CNT_FULL);
  assign q_empty = (count == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = store[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Word storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("queue count beyond depth");

  // A read with a write in the same cycle leaves the count unchanged.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (do_wr && do_rd) |=> $stable(count))
    else $error("queue count moved on simultaneous read and write");

endmodule

`default_nettype wire

[hdl/hcg_back.sv]
// Back half: walks the six direction slots of each queued cell, registering one result per cycle while popped.
// Depends on hcg_pkg.
`default_nettype none

module hcg_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire hcg_pkg::hcg_cfg_t          cfg,
  input  wire hcg_pkg::hcg_entry_t        q_data,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [hcg_pkg::SlotW-1:0]       slot,
  output logic                            neighbor_valid,
  output logic [hcg_pkg::CoordW-1:0]      neighbor_row,
  output logic [hcg_pkg::CoordW-1:0]      neighbor_col,
  output logic [hcg_pkg::PosW-1:0]        centre_x,
  output logic [hcg_pkg::PosW-1:0]        centre_y,
  output logic [hcg_pkg::PosW-1:0]        corner_x,
  output logic [hcg_pkg::PosW-1:0]        corner_y,
  output logic                            outside,
  output logic                            last
);
  import hcg_pkg::*;

  logic               out_valid;
  logic [SlotW-1:0]   cur_slot;
  logic               load;
  logic               odd;
  logic signed [9:0]  nr;
  logic signed [9:0]  nc;
  logic               nvalid;
  logic [DimW-1:0]    rows;
  logic [DimW-1:0]    cols;
  logic [PosW-1:0]    half_w;
  logic [PosW-1:0]    quarter_h;
  logic [PosW-1:0]    half_h;
  logic [PosW-1:0]    cx_next;
  logic [PosW-1:0]    cy_next;

  // A new result is built when a cell waits and the output word is free or leaving.
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && (cur_slot == SLOT_LAST);
  assign empty = !out_valid;

  // Neighbor and corner of the current slot.
  always_comb begin
    rows      = limit_dim(cfg.num_rows);
    cols      = limit_dim(cfg.num_cols);
    odd       = q_data.row[0];
    half_w    = PosW'(cfg.cell_width[GeoW-1:1]);
    half_h    = PosW'(cfg.cell_height[GeoW-1:1]);
    quarter_h = PosW'(cfg.cell_height[GeoW-1:2]);
    nr = $signed({2'b00, q_data.row}) + 10'(nbr_drow(cur_slot));
    nc = $signed({2'b00, q_data.col}) + 10'(nbr_dcol(cur_slot, odd));
    nvalid = !q_data.outside
             && (nr >= 10'sd0) && (nr < $signed({1'b0, rows}))
             && (nc >= 10'sd0) && (nc < $signed({1'b0, cols}));
    case (cur_slot)
      3'd1, 3'd2: cx_next = q_data.centre_x + half_w;
      3'd4, 3'd5: cx_next = q_data.centre_x - half_w;
      default:    cx_next = q_data.centre_x;
    endcase
    case (cur_slot)
      3'd0:       cy_next = q_data.centre_y - half_h;
      3'd1, 3'd5: cy_next = q_data.centre_y - quarter_h;
      3'd2, 3'd4: cy_next = q_data.centre_y + quarter_h;
      3'd3:       cy_next = q_data.centre_y + half_h;
      default:    cy_next = q_data.centre_y;
    endcase
  end

  // Slot counter and output valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_slot  <= SLOT_FIRST;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        cur_slot  <= (cur_slot == SLOT_LAST) ? SLOT_FIRST : cur_slot + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (load) begin
      slot           <= cur_slot;
      neighbor_valid <= nvalid;
      neighbor_row   <= nvalid ? nr[CoordW-1:0] : '0;
      neighbor_col   <= nvalid ? nc[CoordW-1:0] : '0;
      centre_x       <= q_data.centre_x;
      centre_y       <= q_data.centre_y;
      corner_x       <= cx_next;
      corner_y       <= cy_next;
      outside        <= q_data.outside;
      last           <= (cur_slot == SLOT_LAST);
    end
  end

  // The last flag marks the final slot and nothing else.
  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (last == (slot == SLOT_LAST)))
    else $error("last flag does not match slot");

  // A cell outside the grid never reports a valid neighbor.
  a_outside_nbr: assert property (@(posedge clk) disable iff (rst)
    (!empty && outside) |-> !neighbor_valid)
    else $error("valid neighbor on outside cell");

  // The queue is only released after the final slot is built.
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (last && !empty))
    else $error("queue released before final slot");

endmodule

`default_nettype wire

[dv/tb_hex_cell_geometry_and_neighbors.sv]
// Self-checking testbench for the hex cell geometry and neighbor block.
// Depends on hcg_pkg and hex_cell_geometry_and_neighbors; predicts all six words of each cell.
module tb_hex_cell_geometry_and_neighbors;
  import hcg_pkg::*;

  // One result word as the block delivers it.
  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic              nvalid;
    logic [CoordW-1:0] nrow;
    logic [CoordW-1:0] ncol;
    logic [PosW-1:0]   cx;
    logic [PosW-1:0]   cy;
    logic [PosW-1:0]   kx;
    logic [PosW-1:0]   ky;
    logic              out_flag;
    logic              last_flag;
  } hex_word_t;

  // One row of the directed table: a register write or a cell query.
  typedef enum logic {DO_WRITE, DO_QUERY} step_kind_t;
  typedef struct packed {
    step_kind_t        kind;
    hcg_reg_t          idx;
    logic [GeoW-1:0]   data;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              typed;
    logic              exp_out;
    logic [PosW-1:0]   exp_cx;
    logic [PosW-1:0]   exp_cy;
  } plan_step_t;

  localparam int ROW_STEP [SLOTS]      = '{-1, 0, 1, 1, 0, -1};
  localparam int ODD_COL_STEP [SLOTS]  = '{ 1, 1, 1, 0, -1, 0};
  localparam int EVEN_COL_STEP [SLOTS] = '{ 0, 1, 0, -1, -1, -1};
  localparam int GRID_CAP     = (MAX_DIM < 256) ? MAX_DIM : 256;
  localparam int TX_IDLE [3]  = '{29, 56, 0};
  localparam int RX_IDLE [3]  = '{56, 29, 0};
  localparam int PAUSE        = 10;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 150;
  localparam int RAND_PHASES  = 4;
  localparam int RAND_CELLS   = 34;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [GeoW-1:0]   cfg_data = '0;
  logic              push = 1'b0;
  logic [CoordW-1:0] cell_row = '0;
  logic [CoordW-1:0] cell_col = '0;
  logic              pop = 1'b0;
  logic              full;
  logic              empty;
  logic [SlotW-1:0]  slot;
  logic              neighbor_valid;
  logic [CoordW-1:0] neighbor_row;
  logic [CoordW-1:0] neighbor_col;
  logic [PosW-1:0]   centre_x;
  logic [PosW-1:0]   centre_y;
  logic [PosW-1:0]   corner_x;
  logic [PosW-1:0]   corner_y;
  logic              outside;
  logic              last;

  // Shadow of the configuration registers, loaded with the reset values.
  logic [DimW-1:0] grid_rows = 9'd256;
  logic [DimW-1:0] grid_cols = 9'd256;
  logic [GeoW-1:0] hex_w = 16'd443;
  logic [GeoW-1:0] hex_h = 16'd512;

  hex_word_t pending_words [$];
  int mismatches = 0;
  int cells_sent = 0;
  int words_seen = 0;
  int settings_used = 0;
  int tx_idle_pct = TX_IDLE[0];
  int rx_idle_pct = RX_IDLE[0];
  int holds_asked = 0;
  int holds_served = 0;
  int hold_left = 0;

  hex_cell_geometry_and_neighbors uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .cell_row(cell_row),
    .cell_col(cell_col),
    .empty(empty),
    .pop(pop),
    .slot(slot),
    .neighbor_valid(neighbor_valid),
    .neighbor_row(neighbor_row),
    .neighbor_col(neighbor_col),
    .centre_x(centre_x),
    .centre_y(centre_y),
    .corner_x(corner_x),
    .corner_y(corner_y),
    .outside(outside),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic flag_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= 30) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  // A configured dimension clipped to what the 8-bit neighbor fields can reach.
  function automatic int dim_in_use(logic [DimW-1:0] v);
    return (int'(v) > GRID_CAP) ? GRID_CAP : int'(v);
  endfunction

  // Expected word for one slot of a cell under the current shadow configuration.
  function automatic hex_word_t hex_slot_word(logic [CoordW-1:0] r, logic [CoordW-1:0] c,
                                              int k);
    hex_word_t wd;
    int rows, cols, w, h, cx, cy, nr, nc, dx, dy, kx, ky;
    bit odd, off, ok;
    rows = dim_in_use(grid_rows);
    cols = dim_in_use(grid_cols);
    w = int'(hex_w);
    h = int'(hex_h);
    odd = r[0];
    off = (int'(r) >= rows) || (int'(c) >= cols);
    cx = w / 2 + (odd ? w / 2 : 0) + w * int'(c);
    // The quarter is taken of the whole product, not of h alone.
    cy = h / 2 + (3 * int'(r) * h) / 4;
    nr = int'(r) + ROW_STEP[k];
    nc = int'(c) + (odd ? ODD_COL_STEP[k] : EVEN_COL_STEP[k]);
    ok = !off && nr >= 0 && nr < rows && nc >= 0 && nc < cols;
    case (k)
      1, 2:    dx = w / 2;
      4, 5:    dx = -(w / 2);
      default: dx = 0;
    endcase
    case (k)
      0:       dy = -(h / 2);
      3:       dy = h / 2;
      1, 5:    dy = -(h / 4);
      default: dy = h / 4;
    endcase
    kx = cx + dx;
    ky = cy + dy;
    wd.slot = k[SlotW-1:0];
    wd.nvalid = ok;
    wd.nrow = ok ? nr[CoordW-1:0] : '0;
    wd.ncol = ok ? nc[CoordW-1:0] : '0;
    wd.cx = cx[PosW-1:0];
    wd.cy = cy[PosW-1:0];
    wd.kx = kx[PosW-1:0];
    wd.ky = ky[PosW-1:0];
    wd.out_flag = off;
    wd.last_flag = (k == SLOTS - 1);
    return wd;
  endfunction

  function automatic plan_step_t reg_step(hcg_reg_t idx, int data);
    plan_step_t s;
    s = '0;
    s.kind = DO_WRITE;
    s.idx = idx;
    s.data = data[GeoW-1:0];
    return s;
  endfunction

  function automatic plan_step_t query(int r, int c);
    plan_step_t s;
    s = '0;
    s.kind = DO_QUERY;
    s.row = r[CoordW-1:0];
    s.col = c[CoordW-1:0];
    return s;
  endfunction

  // Query whose outside flag and centre are written out by hand.
  function automatic plan_step_t query_exp(int r, int c, bit o, int cx, int cy);
    plan_step_t s;
    s = query(r, c);
    s.typed = 1'b1;
    s.exp_out = o;
    s.exp_cx = cx[PosW-1:0];
    s.exp_cy = cy[PosW-1:0];
    return s;
  endfunction

  // Offer one cell; the six expected words are queued once the block takes it.
  task automatic send_query(plan_step_t s);
    hex_word_t wd;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    push <= 1'b1;
    cell_row <= s.row;
    cell_col <= s.col;
    @(posedge clk);
    while (full) begin
      @(negedge clk);
      @(posedge clk);
    end
    for (int k = 0; k < SLOTS; k++) begin
      wd = hex_slot_word(s.row, s.col, k);
      if (s.typed) begin
        wd.out_flag = s.exp_out;
        wd.cx = s.exp_cx;
        wd.cy = s.exp_cy;
      end
      pending_words.push_back(wd);
    end
    cells_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(hcg_reg_t idx, logic [GeoW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_NUM_ROWS:    grid_rows = data[DimW-1:0];
      REG_NUM_COLS:    grid_cols = data[DimW-1:0];
      REG_CELL_WIDTH:  hex_w = data;
      REG_CELL_HEIGHT: hex_h = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering cells and wait until every expected word has come out.
  task automatic drain_words(int pause);
    int spins;
    spins = 0;
    push <= 1'b0;
    while (pending_words.size() != 0 && spins < DRAIN_LIMIT) begin
      @(negedge clk);
      spins++;
    end
    if (pending_words.size() != 0) begin
      flag_mismatch("words never delivered", 0, pending_words.size());
      pending_words.delete();
    end
    repeat (pause) @(negedge clk);
  endtask

  // Dimensions lean toward the usable range, with the extremes now and then.
  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0:       return 9'd0;
      1:       return 9'd1;
      2:       return 9'd256;
      3:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic logic [GeoW-1:0] pick_geo();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  // Upper data bits above a dimension are don't-care and get random values.
  task automatic random_setting();
    write_reg(REG_NUM_ROWS, {7'($urandom), pick_dim()});
    write_reg(REG_NUM_COLS, {7'($urandom), pick_dim()});
    write_reg(REG_CELL_WIDTH, pick_geo());
    write_reg(REG_CELL_HEIGHT, pick_geo());
    settings_used++;
  endtask

  // Mostly cells inside the grid, often on its edges; the rest anywhere.
  function automatic plan_step_t random_query();
    int rows, cols;
    logic [CoordW-1:0] r, c;
    rows = dim_in_use(grid_rows);
    cols = dim_in_use(grid_cols);
    r = 8'($urandom);
    c = 8'($urandom);
    if (rows > 0 && cols > 0 && $urandom_range(0, 3) != 0) begin
      r = 8'($urandom_range(0, rows - 1));
      c = 8'($urandom_range(0, cols - 1));
      if ($urandom_range(0, 3) == 0) r = ($urandom_range(0, 1) != 0) ? 8'(rows - 1) : 8'd0;
      if ($urandom_range(0, 3) == 0) c = ($urandom_range(0, 1) != 0) ? 8'(cols - 1) : 8'd0;
    end
    return query(r, c);
  endfunction

  // Output side: random pop, with a long hold-off whenever one is asked for.
  always @(negedge clk) begin
    if (hold_left == 0 && holds_served != holds_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Compare each delivered word with the oldest expected one.
  always @(posedge clk) begin : check_words
    hex_word_t wd;
    if (!rst && pop && !empty) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        flag_mismatch("word with no query pending, slot", slot, 0);
      end else begin
        wd = pending_words.pop_front();
        if (slot !== wd.slot) flag_mismatch("slot", slot, wd.slot);
        if (neighbor_valid !== wd.nvalid) flag_mismatch("neighbor_valid", neighbor_valid, wd.nvalid);
        if (neighbor_row !== wd.nrow) flag_mismatch("neighbor_row", neighbor_row, wd.nrow);
        if (neighbor_col !== wd.ncol) flag_mismatch("neighbor_col", neighbor_col, wd.ncol);
        if (centre_x !== wd.cx) flag_mismatch("centre_x", centre_x, wd.cx);
        if (centre_y !== wd.cy) flag_mismatch("centre_y", centre_y, wd.cy);
        if (corner_x !== wd.kx) flag_mismatch("corner_x", corner_x, wd.kx);
        if (corner_y !== wd.ky) flag_mismatch("corner_y", corner_y, wd.ky);
        if (outside !== wd.out_flag) flag_mismatch("outside", outside, wd.out_flag);
        if (last !== wd.last_flag) flag_mismatch("last", last, wd.last_flag);
      end
    end
  end

  // Main sequence: reset, directed table, then random settings under three stall mixes.
  initial begin
    plan_step_t plan [$];
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    plan = '{
      // Reset geometry: corners of the full 256 by 256 grid and two inner cells.
      query_exp(0, 0, 0, 221, 256),
      query_exp(1, 0, 0, 442, 640),
      query_exp(255, 255, 0, 113407, 98176),
      query(0, 255), query(255, 0), query(170, 85), query(85, 170),
      // Small grid with the largest geometry; cells past each edge.
      reg_step(REG_NUM_ROWS, 5), reg_step(REG_NUM_COLS, 7),
      reg_step(REG_CELL_WIDTH, 16'hFFFF), reg_step(REG_CELL_HEIGHT, 16'hFFFF),
      query(0, 0), query(4, 6), query(3, 6), query(2, 7),
      query_exp(255, 255, 1, 16776959, 12566335),
      // No rows at all: every cell is outside.
      reg_step(REG_NUM_ROWS, 0),
      query_exp(0, 0, 1, 32767, 32767),
      // Dimensions beyond the grid reach are clipped; zero-size hexagons.
      reg_step(REG_NUM_ROWS, 16'h01FF), reg_step(REG_NUM_COLS, 16'hFF2C),
      reg_step(REG_CELL_WIDTH, 0), reg_step(REG_CELL_HEIGHT, 0),
      query_exp(255, 255, 0, 0, 0), query_exp(0, 0, 0, 0, 0),
      // Halves and quarters that truncate to nothing.
      reg_step(REG_CELL_WIDTH, 1), reg_step(REG_CELL_HEIGHT, 3),
      query_exp(1, 1, 0, 1, 3), query(2, 2),
      // Single-cell grid, then a grid two columns wide.
      reg_step(REG_NUM_ROWS, 1), reg_step(REG_NUM_COLS, 1),
      query(0, 0), query(0, 1), query(1, 0),
      reg_step(REG_NUM_ROWS, 16'h0100), reg_step(REG_NUM_COLS, 2),
      query(1, 1), query(254, 0), query(255, 1)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == DO_WRITE) begin
        drain_words(PAUSE);
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_query(plan[i]);
      end
    end

    for (int m = 0; m < 3; m++) begin
      tx_idle_pct = TX_IDLE[m];
      rx_idle_pct = RX_IDLE[m];
      for (int p = 0; p < RAND_PHASES; p++) begin
        drain_words(PAUSE);
        random_setting();
        // Once, hold the output side off long enough for the block to back up.
        if (m == 2 && p == 0) holds_asked++;
        repeat (RAND_CELLS) send_query(random_query());
      end
    end
    drain_words(PAUSE);

    $display("Sent %0d cell queries over %0d random grid settings plus the directed table;",
             cells_sent, settings_used);
    $display("checked %0d result words with both sides stalling and one %0d-cycle output hold.",
             words_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
